>>> rtl/core/ssfuv_pkg.sv
package ssfuv_pkg;

  // field and register widths
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W     = 20;
  localparam int SPEED_W   = 16;
  localparam int CR_W      = 6;
  localparam int UV_W      = 17;
  localparam int UV_SHIFT  = 16;

  // clamped grid size and frame total
  localparam int GRID_W = 7;
  localparam int TOT_W  = 2 * GRID_W;

  // largest sheet side, fixed by the column and row field widths
  localparam int MAX_GRID = 64;

  // shared divider: dividend width, quotient bits per cycle
  localparam int DIV_W           = 24;
  localparam int DIV_RADIX_STEPS = 2;
  localparam int DIV_CYC         = DIV_W / DIV_RADIX_STEPS;
  localparam int DIV_CNT_W       = $clog2(DIV_CYC);

  // parameter defaults
  localparam int FRACTION_BITS_DEF = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = CFG_IDX_W'(1);

  // item functions
  localparam logic FUNC_ADVANCE = 1'b0;
  localparam logic FUNC_SET     = 1'b1;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [GRID_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  quotient;
    logic [GRID_W-1:0] remainder;
  } div_rsp_t;

endpackage

>>> rtl/core/ssfuv_cfg_if.sv
interface ssfuv_cfg_if import ssfuv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/ssfuv_in_if.sv
interface ssfuv_in_if import ssfuv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [SPEED_W-1:0] speed;
  logic               loop_enable;
  logic [POS_W-1:0]   new_position;

  modport source (output valid, func, speed, loop_enable, new_position, input ready);
  modport sink (input valid, func, speed, loop_enable, new_position, output ready);
endinterface

>>> rtl/core/ssfuv_out_if.sv
interface ssfuv_out_if import ssfuv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic [CR_W-1:0]  frame_column;
  logic [CR_W-1:0]  frame_row;
  logic [UV_W-1:0]  u_left;
  logic [UV_W-1:0]  u_right;
  logic [UV_W-1:0]  v_top;
  logic [UV_W-1:0]  v_bottom;
  logic             at_end;

  modport source (
    output valid, position, frame_column, frame_row, u_left, u_right, v_top, v_bottom,
    at_end,
    input ready
  );
  modport sink (
    input valid, position, frame_column, frame_row, u_left, u_right, v_top, v_bottom,
    at_end,
    output ready
  );
endinterface

>>> rtl/core/ssfuv_div.sv
module ssfuv_div import ssfuv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     quo_next;
  logic [GRID_W-1:0]    rem;
  logic [GRID_W-1:0]    rem_next;
  logic [GRID_W-1:0]    divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  // restoring division, two quotient bits per cycle
  always_comb begin
    logic [GRID_W:0] trial;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < DIV_RADIX_STEPS; i++) begin
      trial    = {rem_next, quo_next[DIV_W-1]};
      quo_next = {quo_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_next    = GRID_W'(trial - {1'b0, divisor});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[GRID_W-1:0];
      end
    end
  end

  // iteration control and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        quo <= quo_next;
        rem <= rem_next;
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_CYC - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        quo     <= req.dividend;
        rem     <= '0;
        divisor <= req.divisor;
        cnt     <= '0;
        busy    <= 1'b1;
      end
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

>>> rtl/core/sprite_sheet_frame_uv.sv
// channel   modport  handshake      payload
// cfg       sink     valid/ready    index, data (columns = 0, rows = 1)
// item      sink     valid/ready    func, speed, loop_enable, new_position
// result    source   valid/ready    position, frame_column, frame_row, u/v, at_end
//
// a new item is taken only when the last is through: the accept, a multiply step,
// a position update step, then five divisions in turn on the shared two-bit-per-cycle
// divider, then a load of the result register once that register is free
// item.ready is high only while idle; cfg.ready is always high
// a result that waits on result.ready does not block the next item until that item
// is itself finished
// synchronous reset: columns and rows to 1, position to 0, no result pending
module sprite_sheet_frame_uv import ssfuv_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  ssfuv_cfg_if.sink    cfg,
  ssfuv_in_if.sink     item,
  ssfuv_out_if.source  result
);

  localparam int CW = (TOT_W + FRACTION_BITS > POS_W + 1) ? TOT_W + FRACTION_BITS : POS_W + 1;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_POS, S_DIV, S_PUSH} state_t;
  typedef enum logic [2:0] {PH_FRAME, PH_UL, PH_UR, PH_VT, PH_VB} phase_t;

  state_t state;
  phase_t phase;

  logic [CFG_W-1:0]   columns;
  logic [CFG_W-1:0]   rows;
  logic [GRID_W-1:0]  cols_c;
  logic [GRID_W-1:0]  rows_c;

  logic               func_r;
  logic [SPEED_W-1:0] speed_r;
  logic               loop_r;
  logic [POS_W-1:0]   newpos_r;
  logic [TOT_W-1:0]   total;
  logic [POS_W-1:0]   frame_position;
  logic               at_end_r;
  logic [GRID_W-1:0]  col;
  logic [GRID_W-1:0]  row;
  logic [UV_W-1:0]    u_left;
  logic [UV_W-1:0]    u_right;
  logic [UV_W-1:0]    v_top;
  logic [UV_W-1:0]    v_bottom;

  logic [CW-1:0]      end_pos;
  logic [CW-1:0]      last_full;
  logic [CW-1:0]      sum;
  logic [POS_W-1:0]   last_pos;
  logic [POS_W-1:0]   position_next;
  logic               at_end_next;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               res_valid;
  logic [POS_W-1:0]   res_position;
  logic [CR_W-1:0]    res_column;
  logic [CR_W-1:0]    res_row;
  logic [UV_W-1:0]    res_u_left;
  logic [UV_W-1:0]    res_u_right;
  logic [UV_W-1:0]    res_v_top;
  logic [UV_W-1:0]    res_v_bottom;
  logic               res_at_end;
  logic               push;

  function automatic logic [GRID_W-1:0] grid_clamp(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return GRID_W'(1);
    end else if (int'(v) > MAX_GRID) begin
      return GRID_W'(MAX_GRID);
    end else begin
      return GRID_W'(v);
    end
  endfunction

  assign cols_c = grid_clamp(columns);
  assign rows_c = grid_clamp(rows);

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= CFG_W'(1);
      rows    <= CFG_W'(1);
    end else if (cfg.valid) begin
      if (cfg.index == REG_COLUMNS) begin
        columns <= cfg.data;
      end else if (cfg.index == REG_ROWS) begin
        rows <= cfg.data;
      end
    end
  end

  // position update: advance with end test, wrap or hold, saturation; set clamped to the last frame
  always_comb begin
    end_pos   = CW'(total) << FRACTION_BITS;
    last_full = (CW'(total) - CW'(1)) << FRACTION_BITS;
    last_pos  = (last_full > CW'(POS_MAX)) ? POS_MAX : last_full[POS_W-1:0];
    sum       = CW'(frame_position) + CW'(speed_r);
    if (func_r == FUNC_ADVANCE) begin
      if (sum >= end_pos) begin
        position_next = loop_r ? '0 : last_pos;
      end else if (sum > CW'(POS_MAX)) begin
        position_next = POS_MAX;
      end else begin
        position_next = sum[POS_W-1:0];
      end
    end else begin
      position_next = (newpos_r > last_pos) ? last_pos : newpos_r;
    end
    at_end_next = (position_next >= last_pos);
  end

  assign push = (state == S_PUSH) && (!res_valid || result.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase          <= PH_FRAME;
      frame_position <= '0;
      div_req.start  <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      if (res_valid && result.ready && !push) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            func_r   <= item.func;
            speed_r  <= item.speed;
            loop_r   <= item.loop_enable;
            newpos_r <= item.new_position;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          total <= TOT_W'(cols_c) * TOT_W'(rows_c);
          state <= S_POS;
        end
        S_POS: begin
          frame_position   <= position_next;
          at_end_r         <= at_end_next;
          div_req.start    <= 1'b1;
          div_req.dividend <= DIV_W'(position_next >> FRACTION_BITS);
          div_req.divisor  <= cols_c;
          phase            <= PH_FRAME;
          state            <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            unique case (phase)
              PH_FRAME: begin
                col              <= div_rsp.remainder;
                row              <= div_rsp.quotient[GRID_W-1:0];
                div_req.start    <= 1'b1;
                div_req.dividend <= DIV_W'(div_rsp.remainder) << UV_SHIFT;
                div_req.divisor  <= cols_c;
                phase            <= PH_UL;
              end
              PH_UL: begin
                u_left           <= div_rsp.quotient[UV_W-1:0];
                div_req.start    <= 1'b1;
                div_req.dividend <= (DIV_W'(col) + DIV_W'(1)) << UV_SHIFT;
                div_req.divisor  <= cols_c;
                phase            <= PH_UR;
              end
              PH_UR: begin
                u_right          <= div_rsp.quotient[UV_W-1:0];
                div_req.start    <= 1'b1;
                div_req.dividend <= DIV_W'(row) << UV_SHIFT;
                div_req.divisor  <= rows_c;
                phase            <= PH_VT;
              end
              PH_VT: begin
                v_top            <= div_rsp.quotient[UV_W-1:0];
                div_req.start    <= 1'b1;
                div_req.dividend <= (DIV_W'(row) + DIV_W'(1)) << UV_SHIFT;
                div_req.divisor  <= rows_c;
                phase            <= PH_VB;
              end
              PH_VB: begin
                v_bottom <= div_rsp.quotient[UV_W-1:0];
                state    <= S_PUSH;
              end
              default: begin
                phase <= PH_FRAME;
              end
            endcase
          end
        end
        S_PUSH: begin
          if (push) begin
            res_valid    <= 1'b1;
            res_position <= frame_position;
            res_column   <= col[CR_W-1:0];
            res_row      <= row[CR_W-1:0];
            res_u_left   <= u_left;
            res_u_right  <= u_right;
            res_v_top    <= v_top;
            res_v_bottom <= v_bottom;
            res_at_end   <= at_end_r;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ssfuv_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign item.ready          = (state == S_IDLE);
  assign result.valid        = res_valid;
  assign result.position     = res_position;
  assign result.frame_column = res_column;
  assign result.frame_row    = res_row;
  assign result.u_left       = res_u_left;
  assign result.u_right      = res_u_right;
  assign result.v_top        = res_v_top;
  assign result.v_bottom     = res_v_bottom;
  assign result.at_end       = res_at_end;

  // an accepted item always starts the multiply step
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> (state == S_MUL))
    else $error("accepted item did not start the sequencer");

  // divider completions only arrive while the sequencer waits on them
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider finished outside the divide phase");

  // a new division is only requested of an idle divider
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("division requested while the divider is busy");

  // frame split lands inside the sheet
  a_tile_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) |-> ((col < cols_c) && (row < rows_c)))
    else $error("tile index outside the sheet");

  // tile edges are ordered and within one
  a_uv_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) |-> ((u_left < u_right) && (u_right <= UV_W'(1 << UV_SHIFT))
                           && (v_top < v_bottom)))
    else $error("tile texture edges out of order");

endmodule
